[src/csds_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package csds_pkg;

	// Build defaults
	localparam int CSDS_STATIONS = 3;
	localparam int SHOWN_STATIONS = 3;

	// Register map
	localparam logic [2:0] REG_WATER_WAIT = 3'd0;
	localparam logic [2:0] REG_DRY_CONFIRM = 3'd1;
	localparam logic [2:0] REG_CUP_IN = 3'd2;
	localparam logic [2:0] REG_CUP_OUT = 3'd3;
	localparam logic [2:0] REG_DRAW_AFTER = 3'd4;

	localparam logic [7:0] RST_WATER_WAIT = 8'd22;
	localparam logic [7:0] RST_DRY_CONFIRM = 8'd28;
	localparam logic [5:0] RST_CUP_IN = 6'd3;
	localparam logic [5:0] RST_CUP_OUT = 6'd5;
	localparam logic [7:0] RST_DRAW_AFTER = 8'd6;

	// Confirm counters at or above this are cleared before use
	localparam logic [5:0] COUNT_CLEAR_AT = 6'd60;

	// Reported stage codes
	localparam logic [1:0] PHASE_WAIT = 2'd0;
	localparam logic [1:0] PHASE_RUN = 2'd1;
	localparam logic [1:0] PHASE_END = 2'd2;
	localparam logic [1:0] PHASE_DRAIN = 2'd3;

	typedef enum logic [3:0] {
		STG_WAIT  = 4'b0001,
		STG_RUN   = 4'b0010,
		STG_END   = 4'b0100,
		STG_DRAIN = 4'b1000
	} stage_t;

	typedef struct packed {
		logic [7:0] water_wait_ticks;
		logic [7:0] dry_confirm_ticks;
		logic [5:0] cup_in_confirm;
		logic [5:0] cup_out_confirm;
		logic [7:0] draw_after_removal_ticks;
	} cfg_t;

	typedef struct packed {
		logic       scan_tick;
		logic [2:0] cup_present;
		logic [2:0] water_present;
	} in_item_t;

	typedef struct packed {
		logic [2:0] pump_on;
		logic [2:0] drain_pulse;
		logic [2:0] green_led;
		logic [2:0] red_led;
		logic [1:0] phase_a;
		logic [1:0] phase_b;
		logic [1:0] phase_c;
	} out_item_t;

	// What one station reports after the transfer
	typedef struct packed {
		logic       pump;
		logic       pulse;
		logic       green;
		logic       red;
		logic [1:0] phase;
	} lane_out_t;

endpackage

`default_nettype wire

[src/csds_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module csds_lane (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic               tick,
	input  wire logic               cup,
	input  wire logic               water,
	input  wire csds_pkg::cfg_t     cfg,
	output csds_pkg::lane_out_t     view
);
	import csds_pkg::*;

	typedef struct packed {
		logic [5:0] cnt;
		logic       hit;
	} conf_res_t;

	function automatic conf_res_t confirm_step(logic [5:0] cnt, logic match,
			logic [5:0] limit);
		conf_res_t r;
		logic [5:0] c;
		c = (cnt >= COUNT_CLEAR_AT) ? 6'd0 : cnt;
		r.hit = 1'b0;
		if (match) begin
			c = c + 6'd1;
			if (c >= limit) begin
				c = 6'd0;
				r.hit = 1'b1;
			end
		end
		r.cnt = c;
		return r;
	endfunction

	stage_t     stage_q, stage_n;
	logic [7:0] elapsed_q, elapsed_n;
	logic       window_q, window_n;
	logic [7:0] dry_q, dry_n;
	logic       seen_q, seen_n;
	logic [5:0] in_cnt_q, in_cnt_n;
	logic [5:0] out_cnt_q, out_cnt_n;
	logic       pump_q, pump_n;
	logic       green_q, green_n;
	logic       red_q, red_n;
	logic       pulse_n;
	logic       stop;
	conf_res_t  place_r, rm_run_r, rm_end_r;

	// Stages fall through in order within one tick
	always_comb begin
		stage_n   = stage_q;
		elapsed_n = elapsed_q;
		window_n  = window_q;
		dry_n     = dry_q;
		seen_n    = seen_q;
		in_cnt_n  = in_cnt_q;
		out_cnt_n = out_cnt_q;
		pump_n    = pump_q;
		green_n   = green_q;
		red_n     = red_q;
		pulse_n   = 1'b0;
		stop      = 1'b0;
		place_r   = '0;
		rm_run_r  = '0;
		rm_end_r  = '0;

		if (elapsed_n != 8'hFF) begin
			elapsed_n = elapsed_n + 8'd1;
		end

		if (stage_n == STG_WAIT) begin
			green_n = 1'b1;
			place_r = confirm_step(in_cnt_n, cup, cfg.cup_in_confirm);
			in_cnt_n = place_r.cnt;
			if (place_r.hit) begin
				stage_n   = STG_RUN;
				green_n   = 1'b0;
				elapsed_n = 8'd0;
				window_n  = 1'b0;
			end
		end

		if (stage_n == STG_RUN) begin
			red_n  = 1'b1;
			pump_n = 1'b1;
			if (elapsed_n >= cfg.water_wait_ticks && !window_n) begin
				elapsed_n = 8'd0;
				window_n  = 1'b1;
			end
			if (!water) begin
				dry_n = dry_n + 8'd1;
				if (dry_n >= cfg.dry_confirm_ticks) begin
					seen_n = 1'b0;
					dry_n  = 8'd0;
				end
			end else begin
				seen_n = 1'b1;
				dry_n  = 8'd0;
			end
			// removal is only counted when the dry stop does not already hold
			if (!seen_n && window_n) begin
				stop = 1'b1;
			end else begin
				rm_run_r  = confirm_step(out_cnt_n, !cup, cfg.cup_out_confirm);
				out_cnt_n = rm_run_r.cnt;
				stop      = rm_run_r.hit;
			end
			if (stop) begin
				window_n = 1'b1;
				stage_n  = STG_END;
				red_n    = 1'b0;
				pump_n   = 1'b0;
				pulse_n  = 1'b1;
			end else begin
				window_n = 1'b0;
			end
		end

		if (stage_n == STG_END) begin
			window_n  = 1'b0;
			green_n   = !green_n;
			red_n     = !red_n;
			rm_end_r  = confirm_step(out_cnt_n, !cup, cfg.cup_out_confirm);
			out_cnt_n = rm_end_r.cnt;
			if (rm_end_r.hit) begin
				stage_n   = STG_DRAIN;
				red_n     = 1'b0;
				green_n   = 1'b0;
				elapsed_n = 8'd0;
			end
		end

		if (stage_n == STG_DRAIN) begin
			if (elapsed_n <= cfg.draw_after_removal_ticks) begin
				red_n  = !red_n;
				pump_n = 1'b1;
			end else begin
				stage_n   = STG_WAIT;
				pump_n    = 1'b0;
				red_n     = 1'b0;
				green_n   = 1'b0;
				elapsed_n = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q   <= STG_WAIT;
			elapsed_q <= 8'd0;
			window_q  <= 1'b0;
			dry_q     <= 8'd0;
			seen_q    <= 1'b1;
			in_cnt_q  <= 6'd0;
			out_cnt_q <= 6'd0;
			pump_q    <= 1'b0;
			green_q   <= 1'b0;
			red_q     <= 1'b0;
		end else if (step && tick) begin
			stage_q   <= stage_n;
			elapsed_q <= elapsed_n;
			window_q  <= window_n;
			dry_q     <= dry_n;
			seen_q    <= seen_n;
			in_cnt_q  <= in_cnt_n;
			out_cnt_q <= out_cnt_n;
			pump_q    <= pump_n;
			green_q   <= green_n;
			red_q     <= red_n;
		end
	end

	stage_t view_stage;

	// Post-transfer view: stepped state on a tick, held state otherwise
	always_comb begin
		view_stage = tick ? stage_n : stage_q;
		view.pump  = tick ? pump_n : pump_q;
		view.green = tick ? green_n : green_q;
		view.red   = tick ? red_n : red_q;
		view.pulse = tick & pulse_n;
		unique case (view_stage)
			STG_WAIT:  view.phase = PHASE_WAIT;
			STG_RUN:   view.phase = PHASE_RUN;
			STG_END:   view.phase = PHASE_END;
			STG_DRAIN: view.phase = PHASE_DRAIN;
			default:   view.phase = PHASE_WAIT;
		endcase
	end

endmodule

`default_nettype wire

[src/csds_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module csds_merge #(
	parameter int STATIONS = csds_pkg::CSDS_STATIONS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	input  wire csds_pkg::lane_out_t [STATIONS-1:0]  lanes,
	output logic                                     full,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output csds_pkg::out_item_t                      out_data
);
	import csds_pkg::*;

	localparam int NSHOW = (STATIONS < SHOWN_STATIONS) ? STATIONS : SHOWN_STATIONS;

	out_item_t                       item;
	logic [SHOWN_STATIONS-1:0]       pump_b, pulse_b, green_b, red_b;
	logic [SHOWN_STATIONS-1:0][1:0]  phase_b;

	// Gather the shown stations; absent ones read as zero
	always_comb begin
		pump_b  = '0;
		pulse_b = '0;
		green_b = '0;
		red_b   = '0;
		phase_b = '0;
		for (int s = 0; s < NSHOW; s++) begin
			pump_b[s]  = lanes[s].pump;
			pulse_b[s] = lanes[s].pulse;
			green_b[s] = lanes[s].green;
			red_b[s]   = lanes[s].red;
			phase_b[s] = lanes[s].phase;
		end
		item.pump_on     = pump_b;
		item.drain_pulse = pulse_b;
		item.green_led   = green_b;
		item.red_led     = red_b;
		item.phase_a     = phase_b[0];
		item.phase_b     = phase_b[1];
		item.phase_c     = phase_b[2];
	end

	// Two-entry output buffer: head register plus skid
	logic      head_valid_q, skid_valid_q;
	out_item_t head_q, skid_q;
	logic      take;

	assign take      = head_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = head_valid_q;
	assign out_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (head_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				head_valid_q <= 1'b1;
			end
		end else if (take) begin
			head_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				head_q <= skid_q;
			end
		end else if (push) begin
			if (head_valid_q && !take) begin
				skid_q <= item;
			end else begin
				head_q <= item;
			end
		end
	end

endmodule

`default_nettype wire

[src/cup_station_drain_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Cup station drain sequencer: STATIONS stations, one lane each, stepped together
// on every input transfer marked scan_tick; items without the mark only report.
// One item is taken per clock while in_stall is low; its result is registered.
// Each lane steps its whole stage sequence in that transfer. Results leave via a
// two-entry output buffer, so in_stall rises only when both entries hold
// undelivered results. Registers are written over the cfg channel (cfg_ready is
// always high, index 0 water_wait_ticks, 1 dry_confirm_ticks, 2 cup_in_confirm,
// 3 cup_out_confirm, 4 draw_after_removal_ticks, higher indexes ignored) and
// should only be written while the block is idle. Stations from number three up
// see no cup and no water and are not reported.

module cup_station_drain_sequencer #(
	parameter int STATIONS = csds_pkg::CSDS_STATIONS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire csds_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output csds_pkg::out_item_t       out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [7:0]           cfg_data
);
	import csds_pkg::*;

	cfg_t                     cfg_q;
	logic                     accept;
	logic                     buf_full;
	lane_out_t [STATIONS-1:0] lane_view;

	assign cfg_ready = 1'b1;
	assign in_stall  = buf_full;
	assign accept    = in_valid && !buf_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.water_wait_ticks         <= RST_WATER_WAIT;
			cfg_q.dry_confirm_ticks        <= RST_DRY_CONFIRM;
			cfg_q.cup_in_confirm           <= RST_CUP_IN;
			cfg_q.cup_out_confirm          <= RST_CUP_OUT;
			cfg_q.draw_after_removal_ticks <= RST_DRAW_AFTER;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WATER_WAIT:  cfg_q.water_wait_ticks         <= cfg_data;
				REG_DRY_CONFIRM: cfg_q.dry_confirm_ticks        <= cfg_data;
				REG_CUP_IN:      cfg_q.cup_in_confirm           <= cfg_data[5:0];
				REG_CUP_OUT:     cfg_q.cup_out_confirm          <= cfg_data[5:0];
				REG_DRAW_AFTER:  cfg_q.draw_after_removal_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// One lane per station; stations beyond the sensor bits see nothing
	for (genvar s = 0; s < STATIONS; s++) begin : g_lane
		logic cup_s, water_s;
		if (s < SHOWN_STATIONS) begin : g_wired
			assign cup_s   = in_data.cup_present[s];
			assign water_s = in_data.water_present[s];
		end else begin : g_blind
			assign cup_s   = 1'b0;
			assign water_s = 1'b0;
		end
		csds_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (accept),
			.tick   (in_data.scan_tick),
			.cup    (cup_s),
			.water  (water_s),
			.cfg    (cfg_q),
			.view   (lane_view[s])
		);
	end

	// Merge the lanes into one result and buffer it
	csds_merge #(
		.STATIONS (STATIONS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.lanes     (lane_view),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
